/* hdl/rrts_pkg.sv */
// shared types, constants and helpers for the round-robin thread scheduler
// used by round_robin_thread_scheduler_unit and its testbench; no dependencies
package rrts_pkg;

  localparam int MAX_THREADS = 32;
  localparam int TID_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = TID_W;

  typedef logic [MAX_THREADS-1:0] mask_t;
  typedef logic [TID_W-1:0]       tid_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [2:0] {
    ST_INVALID   = 3'd0,
    ST_CREATED   = 3'd1,
    ST_EXECUTING = 3'd2,
    ST_RETURNED  = 3'd3,
    ST_PAUSED    = 3'd4
  } tstate_t;

  typedef enum logic [2:0] {
    OP_YIELD    = 3'd0,
    OP_CREATE   = 3'd1,
    OP_PAUSE    = 3'd2,
    OP_RESUME   = 3'd3,
    OP_RESTART  = 3'd4,
    OP_STOP     = 3'd5,
    OP_QUERY    = 3'd6,
    OP_FINISHED = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ1,
    S_READ2,
    S_EXEC,
    S_WRITE2
  } fsm_t;

  // {found, index} of the lowest set bit
  function automatic logic [TID_W:0] lowest_set(input mask_t m);
    logic [TID_W:0] r;
    r = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, TID_W'(i)};
      end
    end
    return r;
  endfunction

  // state of the thread being switched away from
  function automatic tstate_t leave_rule(input tstate_t s);
    return (s == ST_PAUSED || s == ST_RETURNED) ? s : ST_CREATED;
  endfunction

  // state of the thread being switched to
  function automatic tstate_t enter_rule(input tstate_t s);
    return (s == ST_PAUSED || s == ST_RETURNED) ? s : ST_EXECUTING;
  endfunction

endpackage

/* hdl/round_robin_thread_scheduler_unit.sv */
// top level of the round-robin thread scheduler: command stream in, one result per command out
// depends on rrts_pkg and rrts_ram (thread state table)
//
// channel   dir  width  contents (lowest bit up)
// s_*       in   8      op[2:0], thread_id[7:3]
// m_*       out  16     status[2:0], prev_thread[7:3], next_thread[12:8], switched[13], zero fill
//
// a switching yield goes through read1, read2, exec and write2 before idle; every other
// command, and a yield while no thread is created yet, goes through read1 and exec only:
// the thread state memory has one read port, so a yield reads the left and the entered
// thread one after the other and then writes both back one after the other
// reset (rst, synchronous) clears fsm, count, output valid, table valid bits and enable mask;
// round mask goes to thread 0; unwritten entries read as thread 0 created, others invalid
// the result sits in an output register, so the next command is taken while it waits;
// a command reaching its update step stalls there only while an older result is still held
module round_robin_thread_scheduler_unit
  import rrts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // op[2:0], thread_id[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], prev_thread[7:3], next_thread[12:8], switched[13]
);

  // fsm
  fsm_t state, state_next;

  // scheduler state
  cnt_t  thread_count, thread_count_next;
  mask_t round_mask, round_mask_next;
  mask_t enable_mask, enable_mask_next;
  mask_t tbl_valid;

  // command being worked on
  op_t     cmd_op;
  logic [4:0] cmd_id;
  logic    cmd_yield;   // yield with at least one created thread
  tid_t    tail;
  tid_t    head;
  tstate_t s1;
  tstate_t s2;
  tstate_t head_st;

  // memory ports
  logic    wr_en;
  tid_t    wr_addr;
  tstate_t wr_data;
  tid_t    rd_addr;
  logic [2:0] ram_q;
  tid_t    rd_addr_q;
  logic    rd_hit;
  tstate_t rd_state;

  // exec step results
  logic    ex_wr_en;
  tid_t    ex_wr_addr;
  tstate_t ex_wr_data;
  tstate_t ex_status;
  tid_t    ex_prev;
  tid_t    ex_next;
  logic    ex_sw;

  // output register
  logic       out_valid;
  logic [15:0] out_data;
  logic       out_free;

  logic [TID_W:0] low_round;
  logic [TID_W:0] low_rest;
  mask_t          rest_mask;
  mask_t          id_bit;
  logic           id_ok;
  tid_t           id_t;
  logic [CNT_W:0] count_inc;
  logic           accept;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // yield picks from the current round
  assign low_round = lowest_set(round_mask);
  assign rest_mask = round_mask & (round_mask - mask_t'(1));
  assign low_rest  = lowest_set(rest_mask);

  assign id_t      = cmd_id[TID_W-1:0];
  assign id_ok     = {{(6-CNT_W){1'b0}}, thread_count} >= {1'b0, cmd_id};
  assign id_bit    = mask_t'(1) << id_t;
  assign count_inc = {1'b0, thread_count} + {{CNT_W{1'b0}}, 1'b1};

  rrts_ram #(
    .WIDTH (3),
    .DEPTH (MAX_THREADS)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // entries never written read as their reset value
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    rd_hit    <= tbl_valid[rd_addr];
  end

  always_comb begin
    if (rd_hit) begin
      rd_state = tstate_t'(ram_q);
    end else if (rd_addr_q == '0) begin
      rd_state = ST_CREATED;
    end else begin
      rd_state = ST_INVALID;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_READ1;
      end
      S_READ1: begin
        state_next = cmd_yield ? S_READ2 : S_EXEC;
      end
      S_READ2: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = cmd_yield ? S_WRITE2 : S_IDLE;
      end
      S_WRITE2: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs: ready, read address, write port
  always_comb begin
    s_tready = 1'b0;
    rd_addr  = head;
    wr_en    = 1'b0;
    wr_addr  = ex_wr_addr;
    wr_data  = ex_wr_data;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (op_t'(s_tdata[2:0]) == OP_YIELD) begin
          // tail, or thread 0 when no thread is created yet
          rd_addr = (thread_count != '0) ? low_round[TID_W-1:0] : '0;
        end else begin
          rd_addr = s_tdata[3 +: TID_W];
        end
      end
      S_READ1: begin
        rd_addr = head;
      end
      S_EXEC: begin
        wr_en = ex_wr_en && out_free;
      end
      S_WRITE2: begin
        wr_en   = 1'b1;
        wr_addr = head;
        wr_data = head_st;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  // update step: table write, mask and count changes, result
  always_comb begin
    ex_wr_en          = 1'b0;
    ex_wr_addr        = id_t;
    ex_wr_data        = ST_INVALID;
    ex_status         = ST_INVALID;
    ex_prev           = '0;
    ex_next           = '0;
    ex_sw             = 1'b0;
    thread_count_next = thread_count;
    round_mask_next   = round_mask;
    enable_mask_next  = enable_mask;
    case (cmd_op)
      OP_YIELD: begin
        if (cmd_yield) begin
          // left thread first, entered thread in the following write
          ex_wr_en        = 1'b1;
          ex_wr_addr      = tail;
          ex_wr_data      = leave_rule(s1);
          ex_status       = enter_rule(s2);
          ex_prev         = tail;
          ex_next         = head;
          ex_sw           = 1'b1;
          round_mask_next = (rest_mask == '0) ? enable_mask : rest_mask;
        end else begin
          ex_status = s1;
        end
      end
      OP_CREATE: begin
        if (count_inc < (CNT_W+1)'(MAX_THREADS)) begin
          thread_count_next = count_inc[CNT_W-1:0];
          ex_wr_en          = 1'b1;
          ex_wr_addr        = count_inc[TID_W-1:0];
          ex_wr_data        = ST_CREATED;
          round_mask_next   = round_mask | (mask_t'(1) << count_inc[TID_W-1:0]);
          enable_mask_next  = round_mask_next;
          ex_status         = ST_CREATED;
          ex_next           = count_inc[TID_W-1:0];
        end
      end
      default: begin
        if (id_ok) begin
          ex_wr_addr = id_t;
          case (cmd_op)
            OP_PAUSE: begin
              if (s1 != ST_PAUSED) begin
                ex_wr_en         = 1'b1;
                ex_wr_data       = ST_PAUSED;
                enable_mask_next = enable_mask & ~id_bit;
              end
              ex_status = ST_PAUSED;
            end
            OP_RESUME: begin
              ex_status = s1;
              if (s1 == ST_PAUSED) begin
                ex_wr_en         = 1'b1;
                ex_wr_data       = ST_CREATED;
                enable_mask_next = enable_mask | id_bit;
                ex_status        = ST_CREATED;
              end
            end
            OP_RESTART: begin
              if (s1 != ST_INVALID) begin
                ex_wr_en         = 1'b1;
                ex_wr_data       = ST_CREATED;
                enable_mask_next = enable_mask | id_bit;
                ex_status        = ST_CREATED;
              end
            end
            OP_STOP: begin
              if (s1 != ST_RETURNED) begin
                ex_wr_en         = 1'b1;
                ex_wr_data       = ST_RETURNED;
                enable_mask_next = enable_mask & ~id_bit;
              end
              ex_status = ST_RETURNED;
            end
            OP_QUERY: begin
              ex_status = s1;
            end
            OP_FINISHED: begin
              // enable mask stays as it is
              ex_wr_en   = 1'b1;
              ex_wr_data = ST_RETURNED;
              ex_status  = ST_RETURNED;
            end
            default: begin
              ex_status = ST_INVALID;
            end
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      thread_count <= '0;
      round_mask   <= mask_t'(1);
      enable_mask  <= '0;
      tbl_valid    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        tbl_valid[wr_addr] <= 1'b1;
      end
      if (state == S_EXEC && out_free) begin
        thread_count <= thread_count_next;
        round_mask   <= round_mask_next;
        enable_mask  <= enable_mask_next;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op    <= op_t'(s_tdata[2:0]);
      cmd_id    <= s_tdata[7:3];
      cmd_yield <= (op_t'(s_tdata[2:0]) == OP_YIELD) && (thread_count != '0);
      tail      <= low_round[TID_W] ? low_round[TID_W-1:0] : '0;
      // no bit left, or a bit above the thread count, falls back to thread 0
      if (low_rest[TID_W] && ({1'b0, low_rest[TID_W-1:0]} <= {1'b0, thread_count})) begin
        head <= low_rest[TID_W-1:0];
      end else begin
        head <= '0;
      end
    end
    if (state == S_READ1) begin
      s1 <= rd_state;
    end
    if (state == S_READ2) begin
      s2 <= rd_state;
    end
    if (state == S_EXEC) begin
      head_st <= enter_rule(s2);
    end
    if (state == S_EXEC && out_free) begin
      out_data <= {2'b00, ex_sw, 5'(ex_next), 5'(ex_prev), 3'(ex_status)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

/* hdl/rrts_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sim/tb_top.sv */
// self-checking testbench for round_robin_thread_scheduler_unit: directed table then random commands
// depends on rrts_pkg (op and thread state codes) and the scheduler rtl; checks vs predictor or the table
`timescale 1ns / 100ps

module tb_top;
  import rrts_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // one scheduler answer: the fields carried on m_tdata
  typedef struct packed {
    tstate_t status;
    tid_t    prev;
    tid_t    next;
    logic    sw;
  } sched_res_t;

  // one directed command; answer typed in where fixed is set
  typedef struct packed {
    op_t     op;
    tid_t    id;
    logic    fixed;
    tstate_t status;
    tid_t    prev;
    tid_t    next;
    logic    sw;
  } cmd_row_t;

  localparam int DIR_ROWS = 26;
  localparam cmd_row_t DIR_TABLE [DIR_ROWS] = '{
    // nothing created yet: yield reports thread 0 and does not switch
    '{OP_YIELD,    5'd0,  1'b1, ST_CREATED,  5'd0, 5'd0, 1'b0},
    '{OP_QUERY,    5'd0,  1'b1, ST_CREATED,  5'd0, 5'd0, 1'b0},
    // indexes past the thread count answer invalid
    '{OP_QUERY,    5'd31, 1'b1, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_PAUSE,    5'd1,  1'b1, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_FINISHED, 5'd31, 1'b1, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_RESTART,  5'd31, 1'b1, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_CREATE,   5'd0,  1'b1, ST_CREATED,  5'd0, 5'd1, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    // pause twice: second one leaves the masks alone
    '{OP_PAUSE,    5'd1,  1'b1, ST_PAUSED,   5'd0, 5'd0, 1'b0},
    '{OP_PAUSE,    5'd1,  1'b1, ST_PAUSED,   5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_RESUME,   5'd1,  1'b1, ST_CREATED,  5'd0, 5'd0, 1'b0},
    '{OP_RESUME,   5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_STOP,     5'd1,  1'b1, ST_RETURNED, 5'd0, 5'd0, 1'b0},
    '{OP_RESTART,  5'd1,  1'b1, ST_CREATED,  5'd0, 5'd0, 1'b0},
    '{OP_RESTART,  5'd2,  1'b1, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_FINISHED, 5'd0,  1'b1, ST_RETURNED, 5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_CREATE,   5'd0,  1'b1, ST_CREATED,  5'd0, 5'd2, 1'b0},
    // take every thread out of the enable mask, then let the round run dry
    '{OP_PAUSE,    5'd0,  1'b1, ST_PAUSED,   5'd0, 5'd0, 1'b0},
    '{OP_STOP,     5'd1,  1'b1, ST_RETURNED, 5'd0, 5'd0, 1'b0},
    '{OP_PAUSE,    5'd2,  1'b1, ST_PAUSED,   5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0},
    '{OP_YIELD,    5'd0,  1'b0, ST_INVALID,  5'd0, 5'd0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // op[2:0], thread_id[7:3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[2:0], prev_thread[7:3], next_thread[12:8], switched[13]

  // predictor copy of the scheduler state
  tstate_t thr_state [MAX_THREADS];
  int      thr_count;
  mask_t   round_bits;
  mask_t   enable_bits;

  sched_res_t pending_res [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  int switch_count    = 0;
  int empty_rounds    = 0;
  int full_creates    = 0;
  int stray_ids       = 0;
  int cmd_count       = 0;

  round_robin_thread_scheduler_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // index of the lowest set bit, MAX_THREADS when none
  function automatic int lowest_thread(input mask_t m);
    int r;
    r = MAX_THREADS;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = i;
      end
    end
    return r;
  endfunction

  function automatic void clear_schedule();
    foreach (thr_state[i]) begin
      thr_state[i] = ST_INVALID;
    end
    thr_state[0] = ST_CREATED;
    thr_count    = 0;
    round_bits   = mask_t'(1);
    enable_bits  = '0;
  endfunction

  // applies one command to the predictor state and returns the answer it causes
  function automatic sched_res_t schedule_cmd(input op_t op, input tid_t id);
    sched_res_t r;
    mask_t      rest;
    int         tail;
    int         head;
    tstate_t    ls;
    tstate_t    ns;
    tstate_t    cur;
    r = '{ST_INVALID, '0, '0, 1'b0};
    if (op == OP_YIELD) begin
      if (thr_count == 0) begin
        r.status = thr_state[0];
      end else begin
        tail = lowest_thread(round_bits);
        if (tail >= MAX_THREADS) begin
          tail = 0;
        end
        rest = round_bits & (round_bits - mask_t'(1));
        head = lowest_thread(rest);
        if (head > thr_count) begin
          head = 0;
        end
        ls = thr_state[tail];
        ns = thr_state[head];
        thr_state[tail] = (ls == ST_PAUSED || ls == ST_RETURNED) ? ls : ST_CREATED;
        thr_state[head] = (ns == ST_PAUSED || ns == ST_RETURNED) ? ns : ST_EXECUTING;
        if (rest == '0) begin
          round_bits = enable_bits;
          empty_rounds++;
        end else begin
          round_bits = rest;
        end
        r.status = thr_state[head];
        r.prev   = tid_t'(tail);
        r.next   = tid_t'(head);
        r.sw     = 1'b1;
        switch_count++;
      end
    end else if (op == OP_CREATE) begin
      if (thr_count + 1 < MAX_THREADS) begin
        thr_count++;
        thr_state[thr_count] = ST_CREATED;
        round_bits[thr_count] = 1'b1;
        enable_bits = round_bits;
        r.status = ST_CREATED;
        r.next   = tid_t'(thr_count);
      end else begin
        full_creates++;
      end
    end else if (int'(id) <= thr_count) begin
      cur = thr_state[id];
      case (op)
        OP_PAUSE: begin
          if (cur != ST_PAUSED) begin
            thr_state[id]   = ST_PAUSED;
            enable_bits[id] = 1'b0;
          end
          r.status = ST_PAUSED;
        end
        OP_RESUME: begin
          r.status = cur;
          if (cur == ST_PAUSED) begin
            thr_state[id]   = ST_CREATED;
            enable_bits[id] = 1'b1;
            r.status        = ST_CREATED;
          end
        end
        OP_RESTART: begin
          if (cur != ST_INVALID) begin
            thr_state[id]   = ST_CREATED;
            enable_bits[id] = 1'b1;
            r.status        = ST_CREATED;
          end
        end
        OP_STOP: begin
          if (cur != ST_RETURNED) begin
            thr_state[id]   = ST_RETURNED;
            enable_bits[id] = 1'b0;
          end
          r.status = ST_RETURNED;
        end
        OP_QUERY: begin
          r.status = cur;
        end
        default: begin
          thr_state[id] = ST_RETURNED;
          r.status      = ST_RETURNED;
        end
      endcase
    end else begin
      stray_ids++;
    end
    return r;
  endfunction

  // drives one command, waits for its transfer and queues the answer it must produce
  task automatic issue_cmd(input op_t op, input tid_t id, input bit fixed,
                           input sched_res_t fixed_res);
    sched_res_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {id, op};
    do @(posedge clk); while (!s_tready);
    pred = schedule_cmd(op, id);
    pending_res.push_back(fixed ? fixed_res : pred);
    cmd_count++;
  endtask

  // yields most often; creates rare early so that small thread counts get a long run
  function automatic op_t pick_op(input int create_pct);
    int r;
    r = $urandom_range(99);
    if (r < create_pct) return OP_CREATE;
    r = $urandom_range(99);
    if (r < 40) return OP_YIELD;
    if (r < 50) return OP_PAUSE;
    if (r < 60) return OP_RESUME;
    if (r < 68) return OP_RESTART;
    if (r < 75) return OP_STOP;
    if (r < 87) return OP_QUERY;
    return OP_FINISHED;
  endfunction

  // stimulus: directed table, then four phases of random commands with differing sender idling and receiver stalls
  initial begin
    cmd_row_t   row;
    sched_res_t row_res;
    op_t        op;
    tid_t       id;
    int         done;
    clear_schedule();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row     = DIR_TABLE[i];
      row_res = '{row.status, row.prev, row.next, row.sw};
      issue_cmd(row.op, row.id, row.fixed, row_res);
    end

    done = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        op = pick_op((done < 1000) ? 3 : 15);
        // most commands address an existing thread, the rest any index
        if ($urandom_range(99) < 85) begin
          id = tid_t'($urandom_range(thr_count, 0));
        end else begin
          id = tid_t'($urandom_range(MAX_THREADS - 1, 0));
        end
        issue_cmd(op, id, 1'b0, '0);
        done++;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands, %0d switches, %0d round reloads, %0d creates refused when full",
             cmd_count, switch_count, empty_rounds, full_creates);
    $display("%0d commands to absent threads, final thread count %0d", stray_ids, thr_count);
    if (fail_count == 0 && pending_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random backpressure, compare against the oldest expectation, watchdog
  always @(posedge clk) begin
    sched_res_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (pending_res.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_tdata);
          fail_count++;
        end else begin
          exp_res = pending_res.pop_front();
          if (m_tdata[2:0] != exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[7:3] != exp_res.prev) begin
            $error("prev_thread: expected %0d, got %0d", exp_res.prev, m_tdata[7:3]);
            fail_count++;
          end
          if (m_tdata[12:8] != exp_res.next) begin
            $error("next_thread: expected %0d, got %0d", exp_res.next, m_tdata[12:8]);
            fail_count++;
          end
          if (m_tdata[13] != exp_res.sw) begin
            $error("switched: expected %0d, got %0d", exp_res.sw, m_tdata[13]);
            fail_count++;
          end
          if (m_tdata[15:14] != 2'b00) begin
            $error("fill bits: expected 0, got %0d", m_tdata[15:14]);
            fail_count++;
          end
        end
      end
    end

    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_res.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule
